// ----- hw/rtl/lts_pkg.sv -----
// Shared constants and request codes for the lottery ticket scheduler.
// Used by the channel interfaces and the scheduler top level; no dependencies.
package lts_pkg;

   localparam int OP_W     = 3;
   localparam int SLOT_W   = 4;
   localparam int VALUE_W  = 16;
   localparam int RANDOM_W = 32;

   localparam int NUM_SLOTS_DEF   = 16;
   localparam int TICKET_BITS_DEF = 16;

   localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_RDY  = 3'd2;
   localparam logic [OP_W-1:0] OP_TRANSFER = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE  = 3'd4;

endpackage

// ----- hw/rtl/lts_if.sv -----
// Valid/ready channel interfaces for scheduler requests and responses.
// Depends on lts_pkg for field widths.
interface lts_req_if;
   logic                          valid;
   logic                          ready;
   logic [lts_pkg::OP_W-1:0]      op;
   logic [lts_pkg::SLOT_W-1:0]    slot;
   logic [lts_pkg::SLOT_W-1:0]    dest_slot;
   logic [lts_pkg::VALUE_W-1:0]   ticket_value;
   logic                          ready_flag;
   logic [lts_pkg::RANDOM_W-1:0]  random_word;

   modport source (output valid, op, slot, dest_slot, ticket_value, ready_flag,
                   random_word, input ready);
   modport sink   (input valid, op, slot, dest_slot, ticket_value, ready_flag,
                   random_word, output ready);
endinterface

interface lts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [lts_pkg::SLOT_W-1:0]   winner;
   logic [lts_pkg::VALUE_W-1:0]  moved;
   logic                         error;

   modport source (output valid, found, winner, moved, error, input ready);
   modport sink   (input valid, found, winner, moved, error, output ready);
endinterface

// ----- hw/rtl/lts_ticket_ram.sv -----
// Ticket count memory: one write port, one read port with registered data.
// No package dependencies.
module lts_ticket_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lts_alu.sv -----
// Shared add/subtract unit of the scheduler datapath.
// No package dependencies.
module lts_alu #(
   parameter int WIDTH = 17
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH-1:0] result,
   output logic             flag    // carry out on add, borrow on subtract
);

   logic [WIDTH:0] ext;

   assign ext    = {1'b0, a} + ({1'b0, b} ^ {(WIDTH+1){sub}}) + (WIDTH+1)'(sub);
   assign result = ext[WIDTH-1:0];
   assign flag   = ext[WIDTH];

endmodule

// ----- hw/rtl/lottery_ticket_scheduler.sv -----
// Lottery ticket scheduler top level: slot table, sequencer and response register.
// Load, set ready, release and unknown ops go straight to the response; transfer reads
// and checks both slots, then writes both back unless refused or onto itself; schedule
// runs a sum pass, a 32-step restoring remainder and a walk pass on the one shared
// add/subtract unit, ending after the sum pass with no live tickets. One request at a
// time, the next taken once the response is valid; sync reset clears loaded/ready flags.
module lottery_ticket_scheduler #(
   parameter int NUM_SLOTS   = lts_pkg::NUM_SLOTS_DEF,
   parameter int TICKET_BITS = lts_pkg::TICKET_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   lts_req_if.sink      req_chan,
   lts_rsp_if.source    rsp_chan
);

   // Index and datapath widths follow from the table size and ticket width.
   localparam int IDX_W  = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int SUM_W  = TICKET_BITS + $clog2(NUM_SLOTS);
   localparam int ALU_W  = ((SUM_W > lts_pkg::VALUE_W) ? SUM_W : lts_pkg::VALUE_W) + 1;
   localparam int STEP_W = $clog2(lts_pkg::RANDOM_W);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM,      // add up the tickets of loaded, ready slots
      S_DIV,      // random_word mod total, one bit a cycle
      S_WALK,     // subtract tickets from the remainder until it goes negative
      S_X_SRC,    // read source tickets
      S_X_DST,    // read destination tickets, check source
      S_X_CHK,    // check destination overflow
      S_X_WSRC,   // write back source
      S_X_WDST,   // write back destination
      S_DONE      // hand the result to the response register
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        tag_vld_ff, tag_vld_in;
   logic [IDX_W-1:0]            tag_idx_ff, tag_idx_in;
   logic [SUM_W-1:0]            total_ff, total_in;
   logic [SUM_W-1:0]            rem_ff, rem_in;
   logic [lts_pkg::RANDOM_W-1:0] rnd_ff, rnd_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [IDX_W-1:0]            src_ff, src_in;
   logic [IDX_W-1:0]            dst_ff, dst_in;
   logic                        src_ok_ff, src_ok_in;
   logic                        dst_ok_ff, dst_ok_in;
   logic [lts_pkg::VALUE_W-1:0] amt_ff, amt_in;
   logic                        bad_ff, bad_in;
   logic [TICKET_BITS-1:0]      src_new_ff, src_new_in;
   logic [TICKET_BITS-1:0]      dst_new_ff, dst_new_in;
   logic [NUM_SLOTS-1:0]        loaded_ff, loaded_in;
   logic [NUM_SLOTS-1:0]        ready_ff, ready_in;

   // Result being built, and the response register on the output channel.
   logic                        res_found_ff, res_found_in;
   logic [lts_pkg::SLOT_W-1:0]  res_winner_ff, res_winner_in;
   logic [lts_pkg::VALUE_W-1:0] res_moved_ff, res_moved_in;
   logic                        res_error_ff, res_error_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [lts_pkg::SLOT_W-1:0]  rsp_winner_ff, rsp_winner_in;
   logic [lts_pkg::VALUE_W-1:0] rsp_moved_ff, rsp_moved_in;
   logic                        rsp_error_ff, rsp_error_in;

   // Memory and shared unit hookup.
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [TICKET_BITS-1:0]      wr_data;
   logic [IDX_W-1:0]            rd_addr;
   logic [TICKET_BITS-1:0]      rd_data;
   logic [ALU_W-1:0]            alu_a, alu_b, alu_res;
   logic                        alu_sub, alu_flag;

   logic                        accept;
   logic                        req_slot_ok, req_dst_ok, load_sat;
   logic [IDX_W-1:0]            req_idx, req_dst_idx;
   logic                        issue_more, tag_eligible, same_slot;

   lts_ticket_ram #(
      .DEPTH (NUM_SLOTS),
      .WIDTH (TICKET_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lts_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .flag   (alu_flag)
   );

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign accept          = req_chan.valid && (state_ff == S_IDLE);

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.found  = rsp_found_ff;
   assign rsp_chan.winner = rsp_winner_ff;
   assign rsp_chan.moved  = rsp_moved_ff;
   assign rsp_chan.error  = rsp_error_ff;

   // Decode the incoming request; slots past the table are ignored or refused.
   assign req_slot_ok = 32'(req_chan.slot) < NUM_SLOTS;
   assign req_dst_ok  = 32'(req_chan.dest_slot) < NUM_SLOTS;
   assign req_idx     = IDX_W'(req_chan.slot);
   assign req_dst_idx = IDX_W'(req_chan.dest_slot);
   assign load_sat    = (32'(req_chan.ticket_value) >> TICKET_BITS) != 32'd0;

   assign issue_more   = cnt_ff != CNT_W'(NUM_SLOTS);
   assign tag_eligible = tag_vld_ff && loaded_ff[tag_idx_ff] && ready_ff[tag_idx_ff];
   assign same_slot    = src_ff == dst_ff;

   // Memory ports: writes come from load/release at accept and from transfer
   // write-back; reads walk the table or fetch the transfer operands.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = req_idx;
      wr_data = load_sat ? {TICKET_BITS{1'b1}} : TICKET_BITS'(req_chan.ticket_value);
      rd_addr = cnt_ff[IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_slot_ok &&
                (req_chan.op == lts_pkg::OP_LOAD || req_chan.op == lts_pkg::OP_RELEASE)) begin
               wr_en = 1'b1;
               if (req_chan.op == lts_pkg::OP_RELEASE) begin
                  wr_data = '0;
               end
            end
         end
         S_X_SRC: rd_addr = src_ff;
         S_X_DST: rd_addr = dst_ff;
         S_X_WSRC: begin
            wr_en   = 1'b1;
            wr_addr = src_ff;
            wr_data = src_new_ff;
         end
         S_X_WDST: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            wr_data = dst_new_ff;
         end
         default: ;
      endcase
   end

   // Operand selection for the shared unit.
   always_comb begin
      alu_a   = ALU_W'(total_ff);
      alu_b   = ALU_W'(rd_data);
      alu_sub = 1'b0;
      unique case (state_ff)
         S_DIV: begin
            alu_a   = ALU_W'({rem_ff, rnd_ff[lts_pkg::RANDOM_W-1]});
            alu_b   = ALU_W'(total_ff);
            alu_sub = 1'b1;
         end
         S_WALK: begin
            alu_a   = ALU_W'(rem_ff);
            alu_sub = 1'b1;
         end
         S_X_DST: begin
            alu_a   = ALU_W'(rd_data);
            alu_b   = ALU_W'(amt_ff);
            alu_sub = 1'b1;
         end
         S_X_CHK: begin
            alu_a   = ALU_W'(rd_data);
            alu_b   = ALU_W'(amt_ff);
         end
         default: ;
      endcase
   end

   // Sequencer: next-state and next-register logic.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      tag_vld_in    = 1'b0;
      tag_idx_in    = cnt_ff[IDX_W-1:0];
      total_in      = total_ff;
      rem_in        = rem_ff;
      rnd_in        = rnd_ff;
      step_in       = step_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      src_ok_in     = src_ok_ff;
      dst_ok_in     = dst_ok_ff;
      amt_in        = amt_ff;
      bad_in        = bad_ff;
      src_new_in    = src_new_ff;
      dst_new_in    = dst_new_ff;
      loaded_in     = loaded_ff;
      ready_in      = ready_ff;
      res_found_in  = res_found_ff;
      res_winner_in = res_winner_ff;
      res_moved_in  = res_moved_ff;
      res_error_in  = res_error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_winner_in = rsp_winner_ff;
      rsp_moved_in  = rsp_moved_ff;
      rsp_error_in  = rsp_error_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_found_in  = 1'b0;
               res_winner_in = '0;
               res_moved_in  = '0;
               res_error_in  = 1'b0;
               cnt_in        = '0;
               total_in      = '0;
               rem_in        = '0;
               step_in       = '0;
               rnd_in        = req_chan.random_word;
               src_in        = req_idx;
               dst_in        = req_dst_idx;
               src_ok_in     = req_slot_ok;
               dst_ok_in     = req_dst_ok;
               amt_in        = req_chan.ticket_value;
               state_in      = S_DONE;
               unique case (req_chan.op)
                  lts_pkg::OP_SCHEDULE: state_in = S_SUM;
                  lts_pkg::OP_TRANSFER: state_in = S_X_SRC;
                  lts_pkg::OP_LOAD: begin
                     if (req_slot_ok) begin
                        loaded_in[req_idx] = 1'b1;
                        ready_in[req_idx]  = req_chan.ready_flag;
                     end
                  end
                  lts_pkg::OP_SET_RDY: begin
                     if (req_slot_ok) begin
                        ready_in[req_idx] = req_chan.ready_flag;
                     end
                  end
                  lts_pkg::OP_RELEASE: begin
                     if (req_slot_ok) begin
                        loaded_in[req_idx] = 1'b0;
                        ready_in[req_idx]  = 1'b0;
                     end
                  end
                  default: ;  // unknown op: no change, zero result
               endcase
            end
         end

         S_SUM: begin
            // Issue one read a cycle; accumulate the slot read last cycle.
            if (issue_more) begin
               tag_vld_in = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
            end
            if (tag_eligible) begin
               total_in = alu_res[SUM_W-1:0];
            end
            if (!issue_more && !tag_vld_ff) begin
               state_in = (total_ff == '0) ? S_DONE : S_DIV;
            end
         end

         S_DIV: begin
            // Restoring remainder: shift in the next dividend bit, subtract if it fits.
            if (!alu_flag) begin
               rem_in = alu_res[SUM_W-1:0];
            end else begin
               rem_in = {rem_ff[SUM_W-2:0], rnd_ff[lts_pkg::RANDOM_W-1]};
            end
            rnd_in  = {rnd_ff[lts_pkg::RANDOM_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(lts_pkg::RANDOM_W - 1)) begin
               cnt_in   = '0;
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            // The winner is the first eligible slot whose tickets exceed what is left.
            if (issue_more) begin
               tag_vld_in = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
            end
            if (tag_eligible) begin
               rem_in = alu_res[SUM_W-1:0];
               if (alu_flag) begin
                  res_found_in  = 1'b1;
                  res_winner_in = lts_pkg::SLOT_W'(tag_idx_ff);
                  tag_vld_in    = 1'b0;
                  state_in      = S_DONE;
               end
            end
            if (!issue_more && !tag_vld_ff) begin
               state_in = S_DONE;
            end
         end

         S_X_SRC: state_in = S_X_DST;

         S_X_DST: begin
            // rd_data holds the source count; the unit forms source minus amount.
            bad_in = !src_ok_ff || !dst_ok_ff || (amt_ff == '0) ||
                     !loaded_ff[src_ff] || !loaded_ff[dst_ff] || alu_flag;
            src_new_in = alu_res[TICKET_BITS-1:0];
            state_in   = S_X_CHK;
         end

         S_X_CHK: begin
            // rd_data holds the destination count; the unit forms dest plus amount.
            dst_new_in = alu_res[TICKET_BITS-1:0];
            state_in   = S_DONE;
            if (bad_ff || (!same_slot && (alu_res[ALU_W-1:TICKET_BITS] != '0))) begin
               res_error_in = 1'b1;
            end else if (same_slot) begin
               res_moved_in = amt_ff;
            end else begin
               state_in = S_X_WSRC;
            end
         end

         S_X_WSRC: state_in = S_X_WDST;

         S_X_WDST: begin
            res_moved_in = amt_ff;
            state_in     = S_DONE;
         end

         S_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_winner_in = res_winner_ff;
               rsp_moved_in  = res_moved_ff;
               rsp_error_in  = res_error_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tag_vld_ff   <= 1'b0;
         loaded_ff    <= '0;
         ready_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_vld_ff   <= tag_vld_in;
         loaded_ff    <= loaded_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      tag_idx_ff    <= tag_idx_in;
      total_ff      <= total_in;
      rem_ff        <= rem_in;
      rnd_ff        <= rnd_in;
      step_ff       <= step_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      src_ok_ff     <= src_ok_in;
      dst_ok_ff     <= dst_ok_in;
      amt_ff        <= amt_in;
      bad_ff        <= bad_in;
      src_new_ff    <= src_new_in;
      dst_new_ff    <= dst_new_in;
      res_found_ff  <= res_found_in;
      res_winner_ff <= res_winner_in;
      res_moved_ff  <= res_moved_in;
      res_error_ff  <= res_error_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_winner_ff <= rsp_winner_in;
      rsp_moved_ff  <= rsp_moved_in;
      rsp_error_ff  <= rsp_error_in;
   end

endmodule
